>>> src/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// No dependencies; imported by bpa_div and buddy_page_allocator.
package bpa_pkg;

  localparam int ADDR_W    = 48;
  localparam int ORDER_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int OC_W      = 4;
  localparam int CFG_IDX_W = 1;

  localparam int PAGE_COUNT_DEF = 1024;
  localparam int MAX_ORDERS_DEF = 11;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [OC_W-1:0] OC_RESET = 4'd11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b1;

  typedef struct packed {
    logic               op;
    logic [ORDER_W-1:0] order;
    logic [ADDR_W-1:0]  block_address;
  } bpa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } bpa_out_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
  } bpa_div_req_t;

endpackage

>>> src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for every descriptor store.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/bpa_div.sv
// Splits a 48-bit byte offset into page index and in-page remainder; valid once busy falls.
// Depends on bpa_pkg; the page size must be a power of two, which the block does not check.
module bpa_div import bpa_pkg::*; #(
  parameter int DIVISOR = PAGE_BYTES_DEF,
  localparam int LW = $clog2(DIVISOR)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpa_div_req_t      req,
  output logic              busy,
  output logic [ADDR_W-1:0] quot,
  output logic [LW-1:0]     rem
);

  logic [ADDR_W-1:0] work_r;
  logic [ADDR_W-1:0] quot_r;
  logic [LW-1:0]     rem_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= req.start;
    end
    if (req.start) begin
      work_r <= req.dividend;
    end
    // page index is a shift, the remainder a mask
    if (busy_r) begin
      quot_r <= work_r >> LW;
      rem_r  <= work_r[LW-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

>>> src/buddy_page_allocator.sv
// Buddy page allocator: one transaction in at a time, one result per transaction.
// An allocate scans orders up from the wanted one and takes the head block it finds, first
// requeueing both halves one order lower while it is larger. A free checks its page, marks
// it free, merges it with free buddies and queues it; a free below the pool base is answered
// from idle. A sequencer over the four descriptor RAMs runs these steps; a held result keeps
// in_stall high until it is taken. After reset and after every configuration write a
// clearing pass over all PAGE_COUNT descriptors rebuilds the pool while in_stall is held
// high. PAGE_BYTES must be a power of two. Depends on bpa_pkg, bpa_ram, bpa_div.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int MAX_ORDERS = MAX_ORDERS_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bpa_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bpa_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int PW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int OW   = $clog2(MAX_ORDERS);
  localparam int NW   = $clog2(MAX_ORDERS + 1);
  localparam int KW   = (NW > ORDER_W) ? NW : ORDER_W;
  localparam int LOGP = $clog2(PAGE_COUNT + 1) - 1;
  localparam int TOPN = (MAX_ORDERS < LOGP + 1) ? MAX_ORDERS : LOGP + 1;
  localparam int LW   = $clog2(PAGE_BYTES);
  localparam int SW   = 5;

  localparam logic [SW-1:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_SCAN = 5'd2,  S_AR   = 5'd3;
  localparam logic [SW-1:0] S_AC   = 5'd4,  S_AS1  = 5'd5,  S_AS2  = 5'd6,  S_AS3  = 5'd7;
  localparam logic [SW-1:0] S_AMUL = 5'd8,  S_AADD = 5'd9,  S_FST  = 5'd10, S_FDIV = 5'd11;
  localparam logic [SW-1:0] S_FCHK = 5'd12, S_FC   = 5'd13, S_FL   = 5'd14, S_FB   = 5'd15;
  localparam logic [SW-1:0] S_FM   = 5'd16, S_FI   = 5'd17, S_FEND = 5'd18, S_R0   = 5'd19;
  localparam logic [SW-1:0] S_R1   = 5'd20, S_R2   = 5'd21, S_I0   = 5'd22, S_I1   = 5'd23;
  localparam logic [SW-1:0] S_I2   = 5'd24;

  logic [SW-1:0]     state_r, state_nxt, ret_r, ret_nxt;
  logic [PW-1:0]     x_r, x_nxt, p_r, p_nxt, b_r, b_nxt, h_r, h_nxt, t_r, t_nxt;
  logic [PW-1:0]     c_r, c_nxt;
  logic [OW-1:0]     xk_r, xk_nxt, lv_r, lv_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [ORDER_W-1:0] want_r, want_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt, base_r, base_nxt, prod_r, prod_nxt;
  logic [OC_W-1:0]   order_count_r, order_count_nxt;
  logic [ADDR_W-1:0] pool_base_r, pool_base_nxt;
  logic [PW-1:0]     head_r [MAX_ORDERS];
  logic [PW-1:0]     head_nxt [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] hv_r, hv_nxt;
  logic              clr_first_r, clr_first_nxt;
  logic              out_valid_r, out_valid_nxt;
  bpa_out_t          res_r, res_nxt;

  // descriptor RAM ports
  logic [PW-1:0] rd_addr;
  logic          nx_we, pv_we, od_we, fr_we;
  logic [PW-1:0] nx_waddr, pv_waddr, od_waddr, fr_waddr;
  logic [PW-1:0] nx_wdata, pv_wdata;
  logic [OW-1:0] od_wdata;
  logic          fr_wdata;
  logic [PW-1:0] next_rd, prev_rd;
  logic [OW-1:0] order_rd;
  logic          free_rd;

  bpa_div_req_t      div_req;
  logic              div_busy;
  logic [ADDR_W-1:0] div_quot;
  logic [LW-1:0]     div_rem;

  logic [KW-1:0]     oc_k, n_c, n_m1;
  logic [ADDR_W-1:0] pool_pages;
  logic [PW:0]       fc_mask;
  logic [PW-1:0]     bsel, lo_pg, hi_pg;

  bpa_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(rd_addr), .rdata(next_rd)
  );
  bpa_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(rd_addr), .rdata(prev_rd)
  );
  bpa_ram #(.WIDTH(OW), .DEPTH(PAGE_COUNT)) u_order (
    .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
    .raddr(rd_addr), .rdata(order_rd)
  );
  bpa_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_free (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(rd_addr), .rdata(free_rd)
  );

  bpa_div #(.DIVISOR(PAGE_BYTES)) u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req),
    .busy(div_busy), .quot(div_quot), .rem(div_rem)
  );

  // effective number of orders: clamp to [1, TOPN]
  assign oc_k = KW'(order_count_r);
  always_comb begin
    if (oc_k == '0) begin
      n_c = KW'(1);
    end else if (oc_k > KW'(TOPN)) begin
      n_c = KW'(TOPN);
    end else begin
      n_c = oc_k;
    end
  end
  assign n_m1       = n_c - 1'b1;
  assign pool_pages = ADDR_W'(1) << n_m1;
  assign fc_mask    = ((PW+1)'(1) << order_rd) - 1'b1;
  assign bsel       = p_r ^ (PW'(1) << lv_r);
  assign lo_pg      = (p_r > b_r) ? b_r : p_r;
  assign hi_pg      = (p_r > b_r) ? p_r : b_r;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    x_nxt           = x_r;
    xk_nxt          = xk_r;
    p_nxt           = p_r;
    b_nxt           = b_r;
    h_nxt           = h_r;
    t_nxt           = t_r;
    c_nxt           = c_r;
    lv_nxt          = lv_r;
    k_nxt           = k_r;
    want_nxt        = want_r;
    off_nxt         = off_r;
    base_nxt        = base_r;
    prod_nxt        = prod_r;
    order_count_nxt = order_count_r;
    pool_base_nxt   = pool_base_r;
    head_nxt        = head_r;
    hv_nxt          = hv_r;
    clr_first_nxt   = clr_first_r;
    out_valid_nxt   = out_valid_r && out_stall;
    res_nxt         = res_r;
    rd_addr  = '0;
    nx_we    = 1'b0; nx_waddr = '0; nx_wdata = '0;
    pv_we    = 1'b0; pv_waddr = '0; pv_wdata = '0;
    od_we    = 1'b0; od_waddr = '0; od_wdata = '0;
    fr_we    = 1'b0; fr_waddr = '0; fr_wdata = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = (state_r == S_CLR) ? pool_base_r : off_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_data.op == OP_ALLOC) begin
            want_nxt  = in_data.order;
            k_nxt     = KW'(in_data.order);
            state_nxt = S_SCAN;
          end else if (in_data.block_address < base_r) begin
            res_nxt       = '{address: '0, status: ST_BAD_FREE};
            out_valid_nxt = 1'b1;
          end else begin
            off_nxt   = in_data.block_address - base_r;
            state_nxt = S_FST;
          end
        end
      end
      S_CLR: begin
        div_req.start = clr_first_r;
        clr_first_nxt = 1'b0;
        nx_we = 1'b1; nx_waddr = c_r; nx_wdata = c_r;
        pv_we = 1'b1; pv_waddr = c_r; pv_wdata = c_r;
        od_we = 1'b1; od_waddr = c_r; od_wdata = (c_r == '0) ? OW'(n_m1) : '0;
        fr_we = 1'b1; fr_waddr = c_r; fr_wdata = (c_r == '0);
        if (c_r == PW'(PAGE_COUNT - 1)) begin
          if (!clr_first_r && !div_busy) begin
            base_nxt = pool_base_r - ADDR_W'(div_rem);
            hv_nxt   = '0;
            hv_nxt[n_m1[OW-1:0]] = 1'b1;
            for (int i = 0; i < MAX_ORDERS; i++) begin
              head_nxt[i] = '0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_SCAN: begin
        if (k_r >= n_c) begin
          res_nxt       = '{address: '0, status: ST_NO_BLOCK};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (hv_r[k_r[OW-1:0]]) begin
          p_nxt     = head_r[k_r[OW-1:0]];
          state_nxt = S_AR;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_AR: begin
        rd_addr   = p_r;
        state_nxt = S_AC;
      end
      S_AC: begin
        x_nxt     = p_r;
        state_nxt = S_R0;
        if (KW'(want_r) < KW'(order_rd) && KW'(order_rd) < n_c) begin
          // split: detach the block, then requeue both halves one order lower
          lv_nxt  = order_rd - 1'b1;
          b_nxt   = p_r ^ (PW'(1) << (order_rd - 1'b1));
          xk_nxt  = order_rd;
          ret_nxt = S_AS1;
        end else begin
          fr_we    = 1'b1; fr_waddr = p_r; fr_wdata = 1'b0;
          xk_nxt   = OW'(want_r);
          ret_nxt  = S_AMUL;
        end
      end
      S_AS1: begin
        od_we = 1'b1; od_waddr = p_r; od_wdata = lv_r;
        fr_we = 1'b1; fr_waddr = b_r; fr_wdata = 1'b1;
        state_nxt = S_AS2;
      end
      S_AS2: begin
        od_we = 1'b1; od_waddr = b_r; od_wdata = lv_r;
        x_nxt = p_r; xk_nxt = lv_r; ret_nxt = S_AS3;
        state_nxt = S_I0;
      end
      S_AS3: begin
        x_nxt = b_r; xk_nxt = lv_r; ret_nxt = S_AR;
        state_nxt = S_I0;
      end
      S_AMUL: begin
        prod_nxt  = ADDR_W'(p_r) << LW;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        res_nxt       = '{address: base_r + prod_r, status: ST_DONE};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FST: begin
        div_req.start = 1'b1;
        state_nxt     = S_FDIV;
      end
      S_FDIV: begin
        if (!div_busy) begin
          if (div_rem != '0 || div_quot >= pool_pages) begin
            res_nxt       = '{address: '0, status: ST_BAD_FREE};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            p_nxt     = div_quot[PW-1:0];
            state_nxt = S_FCHK;
          end
        end
      end
      S_FCHK: begin
        rd_addr   = p_r;
        state_nxt = S_FC;
      end
      S_FC: begin
        if (free_rd || KW'(order_rd) >= n_c || ({1'b0, p_r} & fc_mask) != '0) begin
          res_nxt       = '{address: '0, status: ST_BAD_FREE};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          fr_we = 1'b1; fr_waddr = p_r; fr_wdata = 1'b1;
          lv_nxt    = order_rd;
          state_nxt = S_FL;
        end
      end
      S_FL: begin
        if (KW'(lv_r) + 1'b1 < n_c) begin
          b_nxt     = bsel;
          rd_addr   = bsel;
          state_nxt = S_FB;
        end else begin
          state_nxt = S_FI;
        end
      end
      S_FB: begin
        if (!free_rd || order_rd != lv_r) begin
          state_nxt = S_FI;
        end else begin
          x_nxt = b_r; xk_nxt = lv_r; ret_nxt = S_FM;
          state_nxt = S_R0;
        end
      end
      S_FM: begin
        fr_we = 1'b1; fr_waddr = hi_pg; fr_wdata = 1'b0;
        od_we = 1'b1; od_waddr = lo_pg; od_wdata = lv_r + 1'b1;
        p_nxt     = lo_pg;
        lv_nxt    = lv_r + 1'b1;
        state_nxt = S_FL;
      end
      S_FI: begin
        x_nxt = p_r; xk_nxt = lv_r; ret_nxt = S_FEND;
        state_nxt = S_I0;
      end
      S_FEND: begin
        res_nxt       = '{address: '0, status: ST_DONE};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      // list removal of page x from order xk
      S_R0: begin
        rd_addr   = x_r;
        state_nxt = S_R1;
      end
      S_R1: begin
        if (next_rd != x_r) begin
          pv_we = 1'b1; pv_waddr = next_rd; pv_wdata = prev_rd;
          nx_we = 1'b1; nx_waddr = prev_rd; nx_wdata = next_rd;
          head_nxt[xk_r] = next_rd;
          hv_nxt[xk_r]   = 1'b1;
          state_nxt      = S_R2;
        end else begin
          hv_nxt[xk_r] = 1'b0;
          state_nxt    = ret_r;
        end
      end
      S_R2: begin
        nx_we = 1'b1; nx_waddr = x_r; nx_wdata = x_r;
        pv_we = 1'b1; pv_waddr = x_r; pv_wdata = x_r;
        state_nxt = ret_r;
      end
      // list insertion of page x at the head of order xk
      S_I0: begin
        if (hv_r[xk_r]) begin
          h_nxt     = head_r[xk_r];
          rd_addr   = head_r[xk_r];
          state_nxt = S_I1;
        end else begin
          nx_we = 1'b1; nx_waddr = x_r; nx_wdata = x_r;
          pv_we = 1'b1; pv_waddr = x_r; pv_wdata = x_r;
          head_nxt[xk_r] = x_r;
          hv_nxt[xk_r]   = 1'b1;
          state_nxt      = ret_r;
        end
      end
      S_I1: begin
        t_nxt = prev_rd;
        nx_we = 1'b1; nx_waddr = x_r; nx_wdata = h_r;
        pv_we = 1'b1; pv_waddr = x_r; pv_wdata = prev_rd;
        state_nxt = S_I2;
      end
      S_I2: begin
        pv_we = 1'b1; pv_waddr = h_r; pv_wdata = x_r;
        nx_we = 1'b1; nx_waddr = t_r; nx_wdata = x_r;
        head_nxt[xk_r] = x_r;
        hv_nxt[xk_r]   = 1'b1;
        state_nxt      = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // any register write rebuilds the pool
    if (cfg_we) begin
      if (cfg_index == CFG_ORDER_COUNT) begin
        order_count_nxt = cfg_wdata[OC_W-1:0];
      end else begin
        pool_base_nxt = cfg_wdata;
      end
      state_nxt     = S_CLR;
      c_nxt         = '0;
      clr_first_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      c_r           <= '0;
      clr_first_r   <= 1'b1;
      order_count_r <= OC_RESET;
      pool_base_r   <= '0;
      out_valid_r   <= 1'b0;
      hv_r          <= '0;
      ret_r         <= S_IDLE;
    end else begin
      state_r       <= state_nxt;
      c_r           <= c_nxt;
      clr_first_r   <= clr_first_nxt;
      order_count_r <= order_count_nxt;
      pool_base_r   <= pool_base_nxt;
      out_valid_r   <= out_valid_nxt;
      hv_r          <= hv_nxt;
      ret_r         <= ret_nxt;
    end
    x_r    <= x_nxt;
    xk_r   <= xk_nxt;
    p_r    <= p_nxt;
    b_r    <= b_nxt;
    h_r    <= h_nxt;
    t_r    <= t_nxt;
    lv_r   <= lv_nxt;
    k_r    <= k_nxt;
    want_r <= want_nxt;
    off_r  <= off_nxt;
    base_r <= base_nxt;
    prod_r <= prod_nxt;
    head_r <= head_nxt;
    res_r  <= res_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !cfg_we && !(in_data.op == OP_FREE &&
     in_data.block_address < base_r)) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == S_IDLE))
    else $error("result raised while sequencer busy");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != ST_DONE) |-> (res_r.address == '0))
    else $error("failed transaction carries a nonzero address");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("input accepted during clearing pass");

endmodule
